### hdl/lha_level1_member_header_scanner_macros.svh
// Assertion macros used by the result queue of the member header scanner.
`ifndef LHA_LEVEL1_MEMBER_HEADER_SCANNER_MACROS_SVH
`define LHA_LEVEL1_MEMBER_HEADER_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
`define LHA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LHA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define LHA_ASSERT(lbl, prop, msg)
`define LHA_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

### hdl/lha_pkg.sv
// Types, constants and helper functions of the member header scanner.
package lha_pkg;

  localparam int unsigned OFFSET_WIDTH_DEF = 32;
  localparam int unsigned RES_DEPTH        = 4;

  localparam logic [31:0] MAX_ORIG_RST = 32'h1000_0000;
  localparam logic [23:0] MAX_EXT_RST  = 24'h10_0000;
  localparam logic [16:0] MAX_MEM_RST  = 17'h1_0000;

  // Base header layout
  localparam logic [9:0] BASE_FIXED = 10'd27;
  localparam logic [9:0] NAME_START = 10'd22;
  localparam logic [7:0] LEVEL_ONE  = 8'd1;

  typedef enum logic [1:0] {
    CFG_MAX_ORIG = 2'd0,
    CFG_MAX_EXT  = 2'd1,
    CFG_MAX_MEM  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_BASE,
    PH_EXT,
    PH_PAYLOAD,
    PH_DRAIN
  } phase_e;

  typedef enum logic [3:0] {
    ST_MEMBER     = 4'd0,
    ST_END        = 4'd1,
    ST_METHOD     = 4'd2,
    ST_LEVEL      = 4'd3,
    ST_NAME_LEN   = 4'd4,
    ST_CHECKSUM   = 4'd5,
    ST_NAME_CHAR  = 4'd6,
    ST_ORIG_BIG   = 4'd7,
    ST_EXT_LEN    = 4'd8,
    ST_EXT_TOTAL  = 4'd9,
    ST_SIZE       = 4'd10,
    ST_EMPTY      = 4'd11,
    ST_TOO_MANY   = 4'd12,
    ST_TRUNC      = 4'd13
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] header_offset;
    logic [31:0] data_offset;
    logic [31:0] packed_size;
    logic [31:0] unpacked_size;
    logic [31:0] dos_stamp;
    logic [15:0] member_crc;
    logic [7:0]  attribute_byte;
    logic [7:0]  os_id;
    logic        is_stored;
    logic [7:0]  name_len;
    logic        last_of_run;
  } res_t;

  // Up to two results per byte, slot a first
  typedef struct packed {
    logic [1:0] num;
    res_t       a;
    res_t       b;
  } push_t;

  // Method tag characters; index 0..4, stored selects -ARS-
  function automatic logic [7:0] tag_char(input logic [2:0] idx, input logic stored);
    logic [7:0] c;
    unique case (idx)
      3'd0, 3'd4: c = 8'h2D;
      3'd1:       c = 8'h41;
      3'd2:       c = 8'h52;
      3'd3:       c = stored ? 8'h53 : 8'h41;
      default:    c = 8'h00;
    endcase
    return c;
  endfunction

  // Printable, and no path separators or drive colon
  function automatic logic name_ok(input logic [7:0] c);
    return (c >= 8'h20) && (c <= 8'h7E) && (c != 8'h2F) && (c != 8'h5C) && (c != 8'h3A);
  endfunction

endpackage

### hdl/lha_in_if.sv
// Input byte channel: one archive byte per transaction.
interface lha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_input;

  modport source (output valid, data_byte, end_of_input, input ready);
  modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

### hdl/lha_res_if.sv
// Result channel: one member record or status per transaction.
interface lha_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [31:0] header_offset;
  logic [31:0] data_offset;
  logic [31:0] packed_size;
  logic [31:0] unpacked_size;
  logic [31:0] dos_stamp;
  logic [15:0] member_crc;
  logic [7:0]  attribute_byte;
  logic [7:0]  os_id;
  logic        is_stored;
  logic [7:0]  name_len;
  logic        last_of_run;

  modport source (output valid, status, header_offset, data_offset, packed_size,
                  unpacked_size, dos_stamp, member_crc, attribute_byte, os_id,
                  is_stored, name_len, last_of_run, input ready);
  modport sink   (input valid, status, header_offset, data_offset, packed_size,
                  unpacked_size, dos_stamp, member_crc, attribute_byte, os_id,
                  is_stored, name_len, last_of_run, output ready);
endinterface

### hdl/lha_parse_core.sv
// Byte-wise member header parser: state registers and per-byte update logic.
module lha_parse_core #(
  parameter int unsigned OFFSET_WIDTH = lha_pkg::OFFSET_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          byte_i,
  input  logic                eoi_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output lha_pkg::push_t      push_o
);

  typedef logic [OFFSET_WIDTH-1:0] off_t;

  // Configuration
  logic [31:0] max_orig_q;
  logic [23:0] max_ext_q;
  logic [16:0] max_mem_q;

  // Parse state
  lha_pkg::phase_e phase_q, phase_d;
  off_t        off_q, off_d, hs_q, hs_d, hs_cur, off_inc;
  logic [15:0] pos_q, pos_d, cur_q, cur_d;
  logic [8:0]  blen_q, blen_d;
  logic [7:0]  nlen_q, nlen_d, sum_q, sum_d, exp_q, exp_d, lw_q, lw_d;
  logic [1:0]  tag_q, tag_d;
  logic [31:0] skip_q, skip_d, orig_q, orig_d, stamp_q, stamp_d, left_q, left_d;
  logic [7:0]  attr_q, attr_d, os_q, os_d;
  logic [15:0] crc_q, crc_d;
  logic [23:0] ext_q, ext_d;
  logic [16:0] cnt_q, cnt_d;
  logic        nbad_q, nbad_d;

  // Per-byte working values
  logic        off_max;
  logic [8:0]  p9;
  logic [9:0]  p10, n10;
  logic [7:0]  sum_n;
  logic [1:0]  tag_n;
  logic [1:0]  bidx;
  logic        chain_go;
  logic [15:0] chain_w;
  logic [31:0] packed_sz;
  logic        stored;
  logic        e_vld, e_rec, t_vld;
  lha_pkg::status_e e_code;
  lha_pkg::res_t    res_e, res_t13;

  function automatic logic [31:0] to32(input off_t v);
    logic [OFFSET_WIDTH+31:0] w;
    w = {32'b0, v};
    return w[31:0];
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_orig_q <= lha_pkg::MAX_ORIG_RST;
      max_ext_q  <= lha_pkg::MAX_EXT_RST;
      max_mem_q  <= lha_pkg::MAX_MEM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lha_pkg::CFG_MAX_ORIG: max_orig_q <= cfg_data_i;
        lha_pkg::CFG_MAX_EXT:  max_ext_q  <= cfg_data_i[23:0];
        lha_pkg::CFG_MAX_MEM:  max_mem_q  <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  assign off_max   = &off_q;
  assign off_inc   = off_q + 1'b1;
  assign hs_cur    = (phase_q == lha_pkg::PH_LEAD && !off_max) ? off_q : hs_q;
  assign p9        = pos_q[8:0];
  assign p10       = {1'b0, p9};
  assign n10       = lha_pkg::NAME_START + {2'b0, nlen_q};
  assign sum_n     = sum_q + byte_i;
  assign packed_sz = skip_q - {8'b0, ext_q};
  assign stored    = (tag_q == 2'b10);

  // Next state for one accepted byte
  always_comb begin
    phase_d = phase_q; off_d = off_q; hs_d = hs_cur; pos_d = pos_q; cur_d = cur_q;
    blen_d = blen_q; nlen_d = nlen_q; sum_d = sum_q; exp_d = exp_q; lw_d = lw_q;
    tag_d = tag_q; skip_d = skip_q; orig_d = orig_q; stamp_d = stamp_q;
    left_d = left_q; attr_d = attr_q; os_d = os_q; crc_d = crc_q; ext_d = ext_q;
    cnt_d = cnt_q; nbad_d = nbad_q;
    tag_n = tag_q; bidx = 2'd0;
    chain_go = 1'b0; chain_w = 16'd0;
    e_vld = 1'b0; e_rec = 1'b0; e_code = lha_pkg::ST_MEMBER; t_vld = 1'b0;

    if (fire_i) begin
      if (phase_q != lha_pkg::PH_DRAIN) begin
        if (off_max) begin
          e_vld = 1'b1; e_code = lha_pkg::ST_TRUNC;
        end else begin
          unique case (phase_q)
            lha_pkg::PH_LEAD: begin
              if (byte_i == 8'd0) begin
                e_vld  = 1'b1;
                e_code = (cnt_q == 17'd0) ? lha_pkg::ST_EMPTY : lha_pkg::ST_END;
              end else begin
                blen_d = {1'b0, byte_i} + 9'd2;
                pos_d = 16'd1; sum_d = 8'd0; exp_d = 8'd0; tag_d = 2'b11;
                skip_d = '0; orig_d = '0; stamp_d = '0; attr_d = '0; crc_d = '0;
                os_d = '0; lw_d = '0; ext_d = '0; nlen_d = '0; nbad_d = 1'b0;
                phase_d = lha_pkg::PH_BASE;
              end
            end
            lha_pkg::PH_BASE: begin
              pos_d = pos_q + 16'd1;
              if (p9 >= 9'd2) sum_d = sum_n;
              if (p9 == 9'd1) exp_d = byte_i;
              // field captures, little endian
              if (p9 >= 9'd7 && p9 <= 9'd10) begin
                bidx = 2'(p9 - 9'd7);
                skip_d = skip_q | ({24'b0, byte_i} << {bidx, 3'b000});
              end
              if (p9 >= 9'd11 && p9 <= 9'd14) begin
                bidx = 2'(p9 - 9'd11);
                orig_d = orig_q | ({24'b0, byte_i} << {bidx, 3'b000});
              end
              if (p9 >= 9'd15 && p9 <= 9'd18) begin
                bidx = 2'(p9 - 9'd15);
                stamp_d = stamp_q | ({24'b0, byte_i} << {bidx, 3'b000});
              end
              if (p9 == 9'd19) attr_d = byte_i;
              if (p9 >= 9'd2 && p9 <= 9'd6) begin
                if (byte_i != lha_pkg::tag_char(3'(p9 - 9'd2), 1'b0)) tag_n[0] = 1'b0;
                if (byte_i != lha_pkg::tag_char(3'(p9 - 9'd2), 1'b1)) tag_n[1] = 1'b0;
                tag_d = tag_n;
              end
              priority if (p9 >= 9'd2 && p9 <= 9'd6 && tag_n == 2'b00) begin
                e_vld = 1'b1; e_code = lha_pkg::ST_METHOD;
              end else if (p9 == 9'd20 && byte_i != lha_pkg::LEVEL_ONE) begin
                e_vld = 1'b1; e_code = lha_pkg::ST_LEVEL;
              end else if (p9 == 9'd21) begin
                nlen_d = byte_i;
                if (byte_i == 8'd0 ||
                    {1'b0, blen_q} < lha_pkg::BASE_FIXED + {2'b0, byte_i}) begin
                  e_vld = 1'b1; e_code = lha_pkg::ST_NAME_LEN;
                end
              end else if (p9 >= 9'd22) begin
                if (p10 < n10 && !lha_pkg::name_ok(byte_i)) nbad_d = 1'b1;
                if (p10 == n10) crc_d[7:0] = byte_i;
                if (p10 == n10 + 10'd1) crc_d[15:8] = byte_i;
                if (p10 == n10 + 10'd2) os_d = byte_i;
                if (p9 == blen_q - 9'd2) lw_d = byte_i;
                // end of base header
                if (p9 == blen_q - 9'd1) begin
                  priority if (sum_n != exp_q) begin
                    e_vld = 1'b1; e_code = lha_pkg::ST_CHECKSUM;
                  end else if (nbad_q) begin
                    e_vld = 1'b1; e_code = lha_pkg::ST_NAME_CHAR;
                  end else if (orig_q > max_orig_q) begin
                    e_vld = 1'b1; e_code = lha_pkg::ST_ORIG_BIG;
                  end else begin
                    chain_go = 1'b1; chain_w = {byte_i, lw_q};
                  end
                end
              end else begin
              end
            end
            lha_pkg::PH_EXT: begin
              pos_d = pos_q + 16'd1;
              if (pos_q == cur_q - 16'd2) lw_d = byte_i;
              if (pos_q == cur_q - 16'd1) begin
                chain_go = 1'b1; chain_w = {byte_i, lw_q};
              end
            end
            lha_pkg::PH_PAYLOAD: begin
              left_d = left_q - 32'd1;
              if (left_q == 32'd1) phase_d = lha_pkg::PH_LEAD;
            end
            default: ;
          endcase

          // extended header length chain
          if (chain_go) begin
            if (chain_w == 16'd0) begin
              priority if (stored && packed_sz != orig_q) begin
                e_vld = 1'b1; e_code = lha_pkg::ST_SIZE;
              end else if (!stored && packed_sz == 32'd0 && orig_q != 32'd0) begin
                e_vld = 1'b1; e_code = lha_pkg::ST_SIZE;
              end else if (cnt_q >= max_mem_q) begin
                e_vld = 1'b1; e_code = lha_pkg::ST_TOO_MANY;
              end else begin
                e_vld = 1'b1; e_rec = 1'b1;
                cnt_d = cnt_q + 17'd1;
                left_d = packed_sz;
                phase_d = (packed_sz != 32'd0) ? lha_pkg::PH_PAYLOAD : lha_pkg::PH_LEAD;
              end
            end else if (chain_w < 16'd3 || {16'b0, chain_w} > packed_sz) begin
              e_vld = 1'b1; e_code = lha_pkg::ST_EXT_LEN;
            end else if ({1'b0, ext_q} + {9'b0, chain_w} > {1'b0, max_ext_q}) begin
              e_vld = 1'b1; e_code = lha_pkg::ST_EXT_TOTAL;
            end else begin
              ext_d = ext_q + {8'b0, chain_w};
              cur_d = chain_w;
              pos_d = 16'd0;
              phase_d = lha_pkg::PH_EXT;
            end
          end
        end
        if (e_vld && !e_rec) phase_d = lha_pkg::PH_DRAIN;
      end

      off_d = off_max ? off_q : off_inc;

      // final byte: flag truncation unless already draining, then restart
      if (eoi_i) begin
        t_vld = (phase_d != lha_pkg::PH_DRAIN);
        phase_d = lha_pkg::PH_LEAD; off_d = '0; hs_d = '0; pos_d = '0; cur_d = '0;
        blen_d = '0; nlen_d = '0; sum_d = '0; exp_d = '0; lw_d = '0; tag_d = 2'b11;
        skip_d = '0; orig_d = '0; stamp_d = '0; left_d = '0; attr_d = '0;
        os_d = '0; crc_d = '0; ext_d = '0; cnt_d = '0; nbad_d = 1'b0;
      end
    end
  end

  // Result assembly
  always_comb begin
    res_e = '0;
    res_e.status        = e_code;
    res_e.header_offset = to32((e_code == lha_pkg::ST_END) ? off_inc : hs_cur);
    res_e.data_offset   = to32(e_rec ? off_inc : off_q);
    if (e_rec) begin
      res_e.packed_size    = packed_sz;
      res_e.unpacked_size  = orig_q;
      res_e.dos_stamp      = stamp_q;
      res_e.member_crc     = crc_q;
      res_e.attribute_byte = attr_q;
      res_e.os_id          = os_q;
      res_e.is_stored      = stored;
      res_e.name_len       = nlen_q;
    end
    res_e.last_of_run = !t_vld;

    res_t13 = '0;
    res_t13.status        = lha_pkg::ST_TRUNC;
    res_t13.header_offset = to32(hs_cur);
    res_t13.data_offset   = to32(off_q);
    res_t13.last_of_run   = 1'b1;

    push_o.num = {1'b0, e_vld} + {1'b0, t_vld};
    push_o.a   = e_vld ? res_e : res_t13;
    push_o.b   = res_t13;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lha_pkg::PH_LEAD; off_q <= '0; hs_q <= '0; pos_q <= '0; cur_q <= '0;
      blen_q <= '0; nlen_q <= '0; sum_q <= '0; exp_q <= '0; lw_q <= '0; tag_q <= 2'b11;
      skip_q <= '0; orig_q <= '0; stamp_q <= '0; left_q <= '0; attr_q <= '0;
      os_q <= '0; crc_q <= '0; ext_q <= '0; cnt_q <= '0; nbad_q <= 1'b0;
    end else begin
      phase_q <= phase_d; off_q <= off_d; hs_q <= hs_d; pos_q <= pos_d; cur_q <= cur_d;
      blen_q <= blen_d; nlen_q <= nlen_d; sum_q <= sum_d; exp_q <= exp_d; lw_q <= lw_d;
      tag_q <= tag_d; skip_q <= skip_d; orig_q <= orig_d; stamp_q <= stamp_d;
      left_q <= left_d; attr_q <= attr_d; os_q <= os_d; crc_q <= crc_d; ext_q <= ext_d;
      cnt_q <= cnt_d; nbad_q <= nbad_d;
    end
  end

endmodule

### hdl/lha_res_fifo.sv
// Result queue: takes up to two results a cycle, hands out one a cycle while ready_i is high.
`include "lha_level1_member_header_scanner_macros.svh"
module lha_res_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lha_pkg::push_t push_i,
  output logic           room2_o,
  output logic           valid_o,
  input  logic           ready_i,
  output lha_pkg::res_t  data_o
);

  localparam int unsigned Depth = lha_pkg::RES_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  lha_pkg::res_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_nxt;
  logic [CntW-1:0] cnt_q;
  logic            pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign room2_o = (cnt_q <= CntW'(Depth - 2));
  assign wr_nxt  = wr_ptr_q + 1'b1;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_ptr_q] <= push_i.a;
    if (push_i.num == 2'd2) mem_q[wr_nxt]   <= push_i.b;
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.num);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(push_i.num) - CntW'(pop);
    end
  end

  `LHA_ASSERT(a_cnt_bound, cnt_q <= CntW'(Depth), "result queue over full")
  `LHA_ASSERT_IMPL(a_no_overflow, push_i.num != 2'd0, cnt_q <= CntW'(Depth - 2), "push without room")
  `LHA_ASSERT_IMPL(a_pop_drains, pop && push_i.num == 2'd0, ##1 cnt_q == $past(cnt_q) - 1'b1, "pop lost")

endmodule

### hdl/lha_level1_member_header_scanner.sv
// Top level of the LHA level-1 member header scanner.
// Usage: archive bytes arrive on in_i, one byte per transaction, with
// end_of_input set on the last byte of an archive; the parser then restarts
// at offset zero. Results leave on res_o: one record per member, an archive
// end, or a single numbered error, after which bytes are dropped until
// end_of_input. A byte may cause two results; last_of_run marks the last.
// Path: a byte is registered on acceptance and parsed from the input register
// once the queue has room; its results pass through the result queue to res_o.
// Throughput: one byte per cycle while the queue has room; the parse is a
// single pass of compares and adds behind the input register, and a four-entry
// result queue takes both results of one byte in the same cycle.
// Stalls: when res_o.ready is low the queue fills; in_i.ready drops once the
// queue has fewer than two free entries and the input register is occupied.
// Reset clears the parse state and queue and loads the default limits. The
// user must write limits via cfg_* while the block is idle; it is not enforced.
module lha_level1_member_header_scanner #(
  parameter int unsigned OFFSET_WIDTH = lha_pkg::OFFSET_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lha_in_if.sink      in_i,
  lha_res_if.source   res_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic           in_vld_q;
  logic [7:0]     byte_q;
  logic           eoi_q;
  logic           fire;
  logic           room2;
  lha_pkg::push_t push;
  lha_pkg::res_t  res;

  assign fire       = in_vld_q && room2;
  assign in_i.ready = !in_vld_q || fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.data_byte;
      eoi_q  <= in_i.end_of_input;
    end
  end

  lha_parse_core #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .byte_i     (byte_q),
    .eoi_i      (eoi_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push_o     (push)
  );

  lha_res_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room2_o (room2),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res)
  );

  // Result fields
  assign res_o.status         = res.status;
  assign res_o.header_offset  = res.header_offset;
  assign res_o.data_offset    = res.data_offset;
  assign res_o.packed_size    = res.packed_size;
  assign res_o.unpacked_size  = res.unpacked_size;
  assign res_o.dos_stamp      = res.dos_stamp;
  assign res_o.member_crc     = res.member_crc;
  assign res_o.attribute_byte = res.attribute_byte;
  assign res_o.os_id          = res.os_id;
  assign res_o.is_stored      = res.is_stored;
  assign res_o.name_len       = res.name_len;
  assign res_o.last_of_run    = res.last_of_run;

endmodule
